// File: rtl/fla_pkg.sv
package fla_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int ADDR_BITS_DEF = 32;

  localparam int REQ_ADDR_W = 32;
  localparam int PAYLOAD_W  = 16;
  localparam int HEADER_W   = 8;
  localparam int LIMIT_W    = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PAYLOAD_W-1:0] PAYLOAD_RST = 16'd64;
  localparam logic [HEADER_W-1:0]  HEADER_RST  = 8'd16;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 11'd1024;

  typedef enum logic [0:0] {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_NULL_FREE = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAYLOAD   = 2'd0,
    CFG_HEADER    = 2'd1,
    CFG_MAX_SLOTS = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    kind_t                 kind;
    logic [REQ_ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [REQ_ADDR_W-1:0] address_res;
    status_t               status;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
  } cmd_t;

endpackage

// File: rtl/fla_ctrl.sv
module fla_ctrl (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  output fla_pkg::cmd_t cmd
);

  fla_pkg::state_t state_r;
  fla_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fla_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      fla_pkg::S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = fla_pkg::S_EXEC;
        end
      end
      fla_pkg::S_EXEC: begin
        busy      = 1'b1;
        cmd.exec  = 1'b1;
        state_nxt = fla_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fla_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/fla_dpath.sv
module fla_dpath #(
  parameter int MAX_SLOTS = fla_pkg::MAX_SLOTS_DEF,
  parameter int ADDR_BITS = fla_pkg::ADDR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  fla_pkg::cmd_t                      cmd,
  input  fla_pkg::req_t                      in_req,
  input  logic                               cfg_we,
  input  logic [fla_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                               out_valid,
  output fla_pkg::res_t                      out_res
);

  localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (CNT_W > fla_pkg::LIMIT_W) ? CNT_W : fla_pkg::LIMIT_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SLOTS);

  logic [fla_pkg::PAYLOAD_W-1:0] payload_r;
  logic [fla_pkg::HEADER_W-1:0]  header_r;
  logic [fla_pkg::LIMIT_W-1:0]   limit_r;

  logic [CNT_W-1:0]     free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]     used_r, used_nxt;
  logic [ADDR_BITS-1:0] next_off_r, next_off_nxt;

  logic [ADDR_BITS-1:0] stack_mem [MAX_SLOTS];
  logic [ADDR_BITS-1:0] top_r;
  logic [IDX_W-1:0]     rd_idx;
  logic [CNT_W-1:0]     cnt_dec;

  fla_pkg::req_t        req_r;
  logic [ADDR_BITS-1:0] req_addr;
  logic                 push;
  logic                 exhausted;
  logic [ADDR_BITS-1:0] fresh_addr;
  fla_pkg::res_t        res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      payload_r <= fla_pkg::PAYLOAD_RST;
      header_r  <= fla_pkg::HEADER_RST;
      limit_r   <= fla_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (fla_pkg::cfg_idx_t'(cfg_index))
        fla_pkg::CFG_PAYLOAD:   payload_r <= cfg_data;
        fla_pkg::CFG_HEADER:    header_r  <= cfg_data[fla_pkg::HEADER_W-1:0];
        fla_pkg::CFG_MAX_SLOTS: limit_r   <= cfg_data[fla_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
  end

  // The top of stack is read every cycle, so it is ready once a request executes.
  assign cnt_dec = free_cnt_r - CNT_W'(1);
  assign rd_idx  = cnt_dec[IDX_W-1:0];

  always_ff @(posedge clk) begin
    top_r <= stack_mem[rd_idx];
    if (cmd.exec && push) begin
      stack_mem[free_cnt_r[IDX_W-1:0]] <= req_addr;
    end
  end

  assign req_addr   = ADDR_BITS'(req_r.address);
  assign exhausted  = (CMP_W'(used_r) >= CMP_W'(limit_r)) || (used_r >= CNT_FULL);
  assign fresh_addr = next_off_r + ADDR_BITS'(header_r);

  always_comb begin
    push         = 1'b0;
    free_cnt_nxt = free_cnt_r;
    used_nxt     = used_r;
    next_off_nxt = next_off_r;
    res_nxt.address_res = '0;
    res_nxt.status      = fla_pkg::ST_OK;
    if (req_r.kind == fla_pkg::KIND_ALLOC) begin
      priority if (free_cnt_r != '0) begin
        free_cnt_nxt        = cnt_dec;
        res_nxt.address_res = fla_pkg::REQ_ADDR_W'(top_r);
      end else if (exhausted) begin
        res_nxt.status = fla_pkg::ST_EXHAUSTED;
      end else begin
        res_nxt.address_res = fla_pkg::REQ_ADDR_W'(fresh_addr);
        next_off_nxt        = fresh_addr + ADDR_BITS'(payload_r);
        used_nxt            = used_r + CNT_W'(1);
      end
    end else begin
      priority if (req_addr == '0) begin
        res_nxt.status = fla_pkg::ST_NULL_FREE;
      end else if (free_cnt_r >= CNT_FULL) begin
        res_nxt.status = fla_pkg::ST_OVERFLOW;
      end else begin
        push         = 1'b1;
        free_cnt_nxt = free_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= '0;
      used_r     <= '0;
      next_off_r <= '0;
      out_valid  <= 1'b0;
    end else begin
      out_valid <= cmd.exec;
      if (cmd.exec) begin
        free_cnt_r <= free_cnt_nxt;
        used_r     <= used_nxt;
        next_off_r <= next_off_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_res <= res_nxt;
    end
  end

endmodule

// File: rtl/free_list_slot_allocator_core.sv
// Fixed-size slot allocator with a last-in first-out free list and a bump
// pointer. A request is taken when start is high and busy is low; since
// the free-list memory is synchronous, the top entry is read in the cycle
// the request is taken, and the stack and counters are updated in the
// following cycle while busy is high. The result appears on out_res for
// exactly one cycle, marked by out_valid, in the cycle after busy falls,
// and a new request may be started in that same cycle. The receiver
// cannot stall the block, so it must take every result as it comes.
// Configuration registers are written through the cfg_ channel, which is
// always ready, and should only be written while no request is in flight.
module free_list_slot_allocator_core #(
  parameter int MAX_SLOTS = fla_pkg::MAX_SLOTS_DEF,
  parameter int ADDR_BITS = fla_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  fla_pkg::req_t                  in_req,
  output logic                           out_valid,
  output fla_pkg::res_t                  out_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fla_pkg::CFG_DATA_W-1:0] cfg_data
);

  fla_pkg::cmd_t cmd;
  logic          busy_int;

  // Configuration writes go straight into the registers, so the port never waits.
  assign cfg_ready = 1'b1;
  assign busy      = busy_int;

  // The controller sequences each request through capture and execute.
  fla_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy_int),
    .cmd   (cmd)
  );

  // The datapath holds the configuration, counters, bump pointer and the
  // free-list memory, and registers the result.
  fla_dpath #(
    .MAX_SLOTS (MAX_SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import fla_pkg::*;

  // Long enough for every request waiting out the longest sender gap several
  // times over, plus the register writes between phases.
  localparam int CYCLE_LIMIT = 400_000;
  localparam int STACK_DEPTH = MAX_SLOTS_DEF;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  in_req = '0;
  logic                  out_valid;
  res_t                  out_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the allocator: it keeps its own copy of the registers, the
  // free list and the bump pointer, works out the result of every accepted
  // request, and holds those results until the block delivers them.
  class slot_ledger;
    logic [PAYLOAD_W-1:0]  pay_bytes;
    logic [HEADER_W-1:0]   hdr_bytes;
    logic [LIMIT_W-1:0]    slot_cap;
    logic [REQ_ADDR_W-1:0] stack[STACK_DEPTH];
    int unsigned           depth;
    int unsigned           carved;
    logic [REQ_ADDR_W-1:0] bump;
    res_t                  owed[$];
    int                    fails;
    int                    requests;
    int                    settings;
    int                    tally[4];

    function new();
      pay_bytes = PAYLOAD_RST;
      hdr_bytes = HEADER_RST;
      slot_cap  = LIMIT_RST;
      depth     = 0;
      carved    = 0;
      bump      = '0;
      fails     = 0;
      requests  = 0;
      settings  = 0;
      tally     = '{0, 0, 0, 0};
    endfunction

    // Only the low bits that each register holds are kept.
    function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PAYLOAD:   pay_bytes = data[PAYLOAD_W-1:0];
        CFG_HEADER:    hdr_bytes = data[HEADER_W-1:0];
        CFG_MAX_SLOTS: slot_cap  = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function res_t note_request(req_t r);
      res_t        o;
      int unsigned cap;
      o.address_res = '0;
      o.status      = ST_OK;
      cap = (slot_cap < STACK_DEPTH) ? slot_cap : STACK_DEPTH;
      if (r.kind == KIND_ALLOC) begin
        // The free list always wins over carving a fresh slot.
        if (depth > 0) begin
          depth--;
          o.address_res = stack[depth];
        end else if (carved >= cap) begin
          o.status = ST_EXHAUSTED;
        end else begin
          o.address_res = bump + hdr_bytes;
          bump = bump + hdr_bytes + pay_bytes;
          carved++;
        end
      end else if (r.address == '0) begin
        o.status = ST_NULL_FREE;
      end else if (depth >= STACK_DEPTH) begin
        o.status = ST_OVERFLOW;
      end else begin
        stack[depth] = r.address;
        depth++;
      end
      owed.push_back(o);
      requests++;
      return o;
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed.size() == 0) begin
        $error("result with no request outstanding: address_res %h status %s",
               got.address_res, got.status.name());
        fails++;
      end else begin
        want = owed.pop_front();
        if (got.address_res !== want.address_res) begin
          $error("address_res: expected %h, got %h", want.address_res, got.address_res);
          fails++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %s, got %s", want.status.name(), got.status.name());
          fails++;
        end
        tally[int'(want.status)]++;
      end
    endfunction
  endclass

  slot_ledger            ledger = new();
  logic [REQ_ADDR_W-1:0] held[$];   // addresses handed out and not yet freed
  int                    gap_pct;   // chance of a sender gap after a request
  int                    cycles = 0;

  free_list_slot_allocator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results are sampled at the edge that ends their cycle; the block cannot
  // be held off, so every strobe must be taken there and then.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      ledger.check_result(out_res);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               ledger.owed.size());
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Offers one request and returns at the edge that accepts it. Start is
  // left high unless a gap follows, so that back-to-back requests never see
  // start lowered and raised within the same time step.
  task automatic send_req(kind_t kind, logic [REQ_ADDR_W-1:0] addr);
    req_t r;
    res_t pred;
    r.kind    = kind;
    r.address = addr;
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pred = ledger.note_request(r);
    if (kind == KIND_ALLOC && pred.status == ST_OK) held.push_back(pred.address_res);
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Holds the sender off until every outstanding result has come back.
  // At least one edge passes, so start is never driven twice in one step.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (ledger.owed.size() != 0);
  endtask

  // Writes all three registers, and the spare index as well, which the
  // block must ignore. Only called while no request is in flight.
  task automatic configure(logic [CFG_DATA_W-1:0] pay, logic [CFG_DATA_W-1:0] hdr,
                           logic [CFG_DATA_W-1:0] lim);
    cfg_idx_t              regs[4];
    logic [CFG_DATA_W-1:0] vals[4];
    regs = '{CFG_PAYLOAD, CFG_HEADER, CFG_MAX_SLOTS, CFG_UNUSED};
    vals = '{pay, hdr, lim, CFG_DATA_W'($urandom)};
    foreach (regs[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (cfg_ready !== 1'b1) @(posedge clk);
      ledger.write_reg(regs[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    ledger.settings++;
  endtask

  // A random setting that leans towards the extremes. Bits above the header
  // and limit register widths carry junk, which must be dropped.
  task automatic pick_setting();
    logic [CFG_DATA_W-1:0] pay;
    logic [CFG_DATA_W-1:0] hdr;
    logic [CFG_DATA_W-1:0] lim;
    case ($urandom_range(0, 4))
      0: pay = 16'd1;
      1: pay = 16'hFFFF;
      2: pay = 16'd0;
      3: pay = 16'($urandom_range(1, 300));
      default: pay = 16'($urandom);
    endcase
    hdr = 16'($urandom) & 16'hFF00;
    case ($urandom_range(0, 3))
      0: hdr[7:0] = 8'd0;
      1: hdr[7:0] = 8'd1;
      2: hdr[7:0] = 8'hFF;
      default: hdr[7:0] = 8'($urandom);
    endcase
    lim = 16'($urandom) & 16'hF800;
    case ($urandom_range(0, 5))
      0: lim[10:0] = 11'd0;
      1: lim[10:0] = 11'd1;
      2: lim[10:0] = 11'd1024;
      3: lim[10:0] = 11'h7FF;
      // Just past the slots already carved, so exhaustion is reached soon.
      4: lim[10:0] = 11'(ledger.carved + $urandom_range(1, 4));
      default: lim[10:0] = 11'($urandom);
    endcase
    configure(pay, hdr, lim);
  endtask

  // Mostly well-behaved traffic: allocations, and frees of addresses that
  // were handed out. The rest is foreign addresses, null frees and double
  // frees; the block refuses only null frees and frees to a full free list.
  task automatic random_phase(int n);
    int                    roll;
    int                    k;
    logic [REQ_ADDR_W-1:0] a;
    logic [REQ_ADDR_W-1:0] last_freed;
    last_freed = 32'hFFFF_FFFF;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45 || (roll < 80 && held.size() == 0)) begin
        send_req(KIND_ALLOC, $urandom);
      end else if (roll < 80) begin
        k = $urandom_range(0, held.size() - 1);
        a = held[k];
        held.delete(k);
        last_freed = a;
        send_req(KIND_FREE, a);
      end else if (roll < 88) begin
        send_req(KIND_FREE, $urandom);
      end else if (roll < 93) begin
        send_req(KIND_FREE, '0);
      end else begin
        send_req(KIND_FREE, last_freed);
      end
      // A phase that runs without pauses never drains midway.
      if (gap_pct != 0 && $urandom_range(0, 49) == 0) drain();
    end
  endtask

  initial begin
    int                    room;
    logic [REQ_ADDR_W-1:0] a;
    repeat (11) @(posedge clk);
    rst_n   <= 1'b1;
    gap_pct = 30;

    // Reset values: a null free, fresh slots at header 16 and stride 80,
    // then the free list returning addresses last in, first out.
    send_req(KIND_FREE, '0);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_ALLOC, '1);
    send_req(KIND_FREE, '1);
    send_req(KIND_FREE, 32'h0000_0001);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_FREE, 32'h8000_0000);
    send_req(KIND_ALLOC, 32'h5555_AAAA);

    // No fresh slots allowed: the free list is still served first.
    drain();
    configure(16'd64, 16'd16, 16'hF800);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_FREE, 32'h1234_5678);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_ALLOC, '0);

    // Zero header and zero payload: every fresh slot sits at the same offset.
    // A limit above the stack depth is clipped to it.
    drain();
    configure(16'd0, 16'hAB00, 16'h07FF);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_ALLOC, '0);

    // Largest slot size.
    drain();
    configure(16'hFFFF, 16'h00FF, 16'h0400);
    send_req(KIND_ALLOC, '0);
    send_req(KIND_ALLOC, '0);

    // Push a run of addresses onto the free list, then pop the whole list
    // back, which must return them in reverse order.
    drain();
    for (int i = 0; i < 48; i++) begin
      a = $urandom;
      if (a == '0) a = 32'h0000_0001;
      send_req(KIND_FREE, a);
    end
    room = ledger.depth;
    for (int i = 0; i < room; i++) send_req(KIND_ALLOC, '0);
    held.delete();

    // Random traffic over a series of settings; the last phase runs with
    // the sender never pausing.
    for (int p = 0; p < 8; p++) begin
      drain();
      pick_setting();
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 50;
      endcase
      if (p == 7) gap_pct = 0;
      random_phase(92);
    end

    drain();
    repeat (8) @(posedge clk);

    $display("%0d requests over %0d register settings, %0d slots carved from the region",
             ledger.requests, ledger.settings, ledger.carved);
    $display("results: %0d ok, %0d exhausted, %0d null frees, %0d overflows",
             ledger.tally[0], ledger.tally[1], ledger.tally[2], ledger.tally[3]);
    if (ledger.fails == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
